[design/route_cache_lru_with_flush_unit_assert.svh]
// Assertion macros shared by the route cache checker.
`ifndef ROUTE_CACHE_LRU_WITH_FLUSH_UNIT_ASSERT_SVH
`define ROUTE_CACHE_LRU_WITH_FLUSH_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RCLRU_ASSERT_IMP(label, a_clk, a_rst, ante, cons) \
  label: assert property (@(posedge a_clk) disable iff (a_rst) (ante) |-> (cons)) \
    else $error("route cache assertion failed");

// Next-cycle implication, disabled during reset.
`define RCLRU_ASSERT_NXT(label, a_clk, a_rst, ante, cons) \
  label: assert property (@(posedge a_clk) disable iff (a_rst) (ante) |=> (cons)) \
    else $error("route cache assertion failed");

`endif

[design/rclru_pkg.sv]
// Shared types, constants and control structs of the route cache.
package rclru_pkg;

  localparam int DEF_ENTRIES   = 16;
  localparam int DEF_CELL_BITS = 16;

  localparam int CFG_W     = 5;
  localparam int CELL_W    = 16;
  localparam int KEY_W     = 16;
  localparam int REV_W     = 64;
  localparam int STAMP_W   = 64;
  localparam int SLOT_W    = 4;
  localparam int COUNT_W   = 5;

  localparam logic [CFG_W-1:0] CAPACITY_RESET = 5'd16;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // Request transaction payload
  typedef struct packed {
    logic                     opcode;
    logic [CELL_W-1:0]        start_cell;
    logic [CELL_W-1:0]        goal_cell;
    logic [REV_W-1:0]         world_revision;
    logic signed [KEY_W-1:0]  hover_q;
    logic signed [KEY_W-1:0]  radius_q;
    logic signed [KEY_W-1:0]  step_q;
  } req_t;

  // Response transaction payload
  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               evicted;
    logic               flushed;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic eval;
    logic scan_start;
    logic scan_step;
    logic evict;
    logic commit;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_evict;
    logic scan_done;
    logic out_busy;
  } ctl_sts_t;

endpackage

[design/rclru_ram.sv]
// Generic single write port RAM with one registered read port.
module rclru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/rclru_ctrl.sv]
// Controller state machine that sequences each request through the datapath.
module rclru_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  rclru_pkg::ctl_sts_t sts,
  output rclru_pkg::ctl_cmd_t cmd
);
  import rclru_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN,
    S_COMMIT
  } state_t;

  state_t state;
  state_t state_next;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EVAL;
      end
      S_EVAL: begin
        state_next = sts.need_evict ? S_SCAN : S_COMMIT;
      end
      S_SCAN: begin
        if (sts.scan_done) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (!sts.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Commands follow the current state; no request is taken during reset
  always_comb begin
    req_ready      = (state == S_IDLE) && !rst;
    cmd            = '0;
    cmd.load       = (state == S_IDLE) && !rst && req_valid;
    cmd.eval       = (state == S_EVAL);
    cmd.scan_start = (state == S_EVAL) && sts.need_evict;
    cmd.scan_step  = (state == S_SCAN);
    cmd.evict      = (state == S_SCAN) && sts.scan_done;
    cmd.commit     = (state == S_COMMIT) && !sts.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[design/rclru_datapath.sv]
// Tag lanes, stamp memory, victim scan and response register of the route cache.
module rclru_datapath #(
  parameter int ENTRIES   = rclru_pkg::DEF_ENTRIES,
  parameter int CELL_BITS = rclru_pkg::DEF_CELL_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rclru_pkg::req_t               req,
  input  logic                          cfg_we,
  input  logic [rclru_pkg::CFG_W-1:0]   cfg_wdata,
  input  rclru_pkg::ctl_cmd_t           cmd,
  output rclru_pkg::ctl_sts_t           sts,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output rclru_pkg::rsp_t               rsp
);
  import rclru_pkg::*;

  localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW    = $clog2(ENTRIES + 1);
  localparam int KCW   = (CELL_BITS < CELL_W) ? CELL_BITS : CELL_W;
  localparam int RAM_W = STAMP_W + KCW;

  // Held state
  logic [CFG_W-1:0]   capacity;
  logic [ENTRIES-1:0] valid;
  logic [CW-1:0]      count;
  logic [REV_W-1:0]   held_rev;
  logic [STAMP_W-1:0] use_clock;

  // Per-request working registers
  req_t               req_r;
  logic [ENTRIES-1:0] eff_valid;
  logic [CW-1:0]      count_eff;
  logic               flushed_r;
  logic               evicted_r;

  // Key lanes
  logic [KCW-1:0]   e_start  [ENTRIES];
  logic [KCW-1:0]   e_goal   [ENTRIES];
  logic [KEY_W-1:0] e_hover  [ENTRIES];
  logic [KEY_W-1:0] e_radius [ENTRIES];
  logic [KEY_W-1:0] e_step   [ENTRIES];

  // Victim scan
  logic [CW-1:0]      scan_k;
  logic               pend;
  logic [IW-1:0]      pend_idx;
  logic               best_found;
  logic [STAMP_W-1:0] best_stamp;
  logic [KCW-1:0]     best_start;
  logic [IW-1:0]      best_idx;

  logic               rev_change;
  logic [CW-1:0]      cnt_eval;
  logic [CW-1:0]      cap_eff;
  logic [7:0]         cap_wide;
  logic [KCW-1:0]     key_s;
  logic [KCW-1:0]     key_g;
  logic [ENTRIES-1:0] match_vec;
  logic               match_any;
  logic [IW-1:0]      match_idx;
  logic [IW-1:0]      free_idx;
  logic               is_ins;
  logic [IW-1:0]      wr_slot;
  logic               do_write;
  logic [STAMP_W-1:0] stamp_next;
  logic [ENTRIES-1:0] valid_new;
  logic [CW-1:0]      count_new;
  logic [RAM_W-1:0]   rdata;
  logic [STAMP_W-1:0] rd_stamp;
  logic [KCW-1:0]     rd_start;
  logic               cand_better;
  logic               cand_take;

  // Flush detection and effective capacity
  always_comb begin
    rev_change = (req_r.world_revision != held_rev);
    cnt_eval   = rev_change ? '0 : count;
    cap_wide   = {3'b000, capacity};
    if (cap_wide == 8'd0) begin
      cap_eff = CW'(1);
    end else if (cap_wide > 8'(ENTRIES)) begin
      cap_eff = CW'(ENTRIES);
    end else begin
      cap_eff = CW'(cap_wide);
    end
    is_ins         = (req_r.opcode == OP_INSERT);
    sts.need_evict = is_ins && (cnt_eval >= cap_eff);
    sts.scan_done  = (scan_k == CW'(ENTRIES)) && !pend;
    sts.out_busy   = rsp_valid && !rsp_ready;
  end

  assign key_s = req_r.start_cell[KCW-1:0];
  assign key_g = req_r.goal_cell[KCW-1:0];

  // Parallel key compare, lowest matching and lowest free slot
  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] = eff_valid[i] && (e_start[i] == key_s) && (e_goal[i] == key_g) &&
                     (e_hover[i] == req_r.hover_q) && (e_radius[i] == req_r.radius_q) &&
                     (e_step[i] == req_r.step_q);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) match_idx = IW'(i);
      if (!eff_valid[i]) free_idx = IW'(i);
    end
    match_any = |match_vec;
  end

  // Commit values
  always_comb begin
    wr_slot    = (is_ins && !match_any) ? free_idx : match_idx;
    do_write   = cmd.commit && (is_ins || match_any);
    stamp_next = use_clock + STAMP_W'(1);
    valid_new  = eff_valid;
    if (is_ins) valid_new[wr_slot] = 1'b1;
    count_new  = count_eff + ((is_ins && !match_any) ? CW'(1) : CW'(0));
  end

  // Stamp memory: last use stamp and start cell per slot
  rclru_ram #(
    .WIDTH (RAM_W),
    .DEPTH (ENTRIES)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (do_write),
    .waddr (wr_slot),
    .wdata ({stamp_next, key_s}),
    .raddr (scan_k[IW-1:0]),
    .rdata (rdata)
  );

  // Least recent use compare, ties to smaller start cell then lower slot
  always_comb begin
    rd_stamp    = rdata[RAM_W-1 -: STAMP_W];
    rd_start    = rdata[KCW-1:0];
    cand_better = !best_found || (rd_stamp < best_stamp) ||
                  ((rd_stamp == best_stamp) && (rd_start < best_start));
    cand_take   = pend && eff_valid[pend_idx] && cand_better;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= CAPACITY_RESET;
      valid      <= '0;
      count      <= '0;
      held_rev   <= '0;
      use_clock  <= '0;
      rsp_valid  <= 1'b0;
      scan_k     <= '0;
      pend       <= 1'b0;
      best_found <= 1'b0;
    end else begin
      if (cfg_we) capacity <= cfg_wdata;
      if (cmd.scan_start) begin
        scan_k     <= '0;
        pend       <= 1'b0;
        best_found <= 1'b0;
      end else if (cmd.scan_step) begin
        if (scan_k != CW'(ENTRIES)) begin
          scan_k <= scan_k + CW'(1);
          pend   <= 1'b1;
        end else begin
          pend <= 1'b0;
        end
        if (cand_take) best_found <= 1'b1;
      end
      if (cmd.commit) begin
        valid     <= valid_new;
        count     <= count_new;
        held_rev  <= req_r.world_revision;
        rsp_valid <= 1'b1;
        if (is_ins || match_any) use_clock <= stamp_next;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= req;
    if (cmd.eval) begin
      eff_valid <= rev_change ? '0 : valid;
      count_eff <= cnt_eval;
      flushed_r <= rev_change && (count != '0);
      evicted_r <= 1'b0;
    end else if (cmd.evict) begin
      eff_valid[best_idx] <= 1'b0;
      count_eff           <= count_eff - CW'(1);
      evicted_r           <= 1'b1;
    end
    if (cmd.scan_step) pend_idx <= scan_k[IW-1:0];
    if (cmd.scan_step && cand_take) begin
      best_stamp <= rd_stamp;
      best_start <= rd_start;
      best_idx   <= pend_idx;
    end
    if (cmd.commit && is_ins) begin
      e_start[wr_slot]  <= key_s;
      e_goal[wr_slot]   <= key_g;
      e_hover[wr_slot]  <= req_r.hover_q;
      e_radius[wr_slot] <= req_r.radius_q;
      e_step[wr_slot]   <= req_r.step_q;
    end
    if (cmd.commit) begin
      rsp.hit         <= !is_ins && match_any;
      rsp.slot        <= (is_ins || match_any) ? SLOT_W'(wr_slot) : '0;
      rsp.evicted     <= evicted_r;
      rsp.flushed     <= flushed_r;
      rsp.entry_count <= COUNT_W'(count_new);
    end
  end

endmodule

[design/route_cache_lru_with_flush_unit.sv]
// Top level of the route cache tag store: controller plus datapath.
// Fully associative LRU tag store for route keys, flushed whenever the world
// revision changes. One request is in flight at a time. A lookup, or an insert
// into a cache below capacity, passes through evaluate and commit and back to
// idle before the next acceptance; the response is registered at commit. An
// insert into a full cache scans the stamp RAM one slot per read cycle to find
// the victim between evaluate and commit. A pending response that is not taken
// holds the block in its commit step. Valid bits are flip-flops, so there is
// no clearing pass after reset. The capacity register may be written only
// while idle.
module route_cache_lru_with_flush_unit #(
  parameter int ENTRIES   = rclru_pkg::DEF_ENTRIES,
  parameter int CELL_BITS = rclru_pkg::DEF_CELL_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  rclru_pkg::req_t             req,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output rclru_pkg::rsp_t             rsp,
  input  logic                        cfg_we,
  input  logic [rclru_pkg::CFG_W-1:0] cfg_wdata
);
  import rclru_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // Sequencer
  rclru_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Storage and compare logic
  rclru_datapath #(
    .ENTRIES   (ENTRIES),
    .CELL_BITS (CELL_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

[design/rclru_checker.sv]
// Port-level assertions for the route cache, bound to the top level.
`include "route_cache_lru_with_flush_unit_assert.svh"

module rclru_checker #(
  parameter int ENTRIES = rclru_pkg::DEF_ENTRIES
) (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_ready,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input rclru_pkg::rsp_t rsp
);
  import rclru_pkg::*;

  // A stalled response transaction stays offered
  `RCLRU_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)

  // One request at a time: no acceptance right after an acceptance
  `RCLRU_ASSERT_NXT(a_one_in_flight, clk, rst, req_valid && req_ready, !req_ready)

  // A hit never comes with an eviction
  `RCLRU_ASSERT_IMP(a_hit_no_evict, clk, rst, rsp_valid && rsp.hit, !rsp.evicted)

  // Hits and evicting inserts leave at least one entry, never more than the store
  `RCLRU_ASSERT_IMP(a_count_sane, clk, rst, rsp_valid && (rsp.hit || rsp.evicted),
                    (rsp.entry_count != '0) && (int'(rsp.entry_count) <= ENTRIES))

endmodule

bind route_cache_lru_with_flush_unit rclru_checker #(
  .ENTRIES (ENTRIES)
) u_rclru_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

[tb/sv/tb.sv]
// Self-checking testbench for the route cache tag store with LRU eviction and flush.
`timescale 1ns / 1ps

module tb;
  import rclru_pkg::*;

  localparam int ENTRIES    = DEF_ENTRIES;
  localparam int POOL_KEYS  = 20;
  localparam int PHASES     = 12;
  localparam int PHASE_REQS = 120;
  localparam int CYCLE_CAP  = 400000;

  // Key as compared by the tag store
  typedef struct packed {
    logic [CELL_W-1:0] start_cell;
    logic [CELL_W-1:0] goal_cell;
    logic [KEY_W-1:0]  hover_q;
    logic [KEY_W-1:0]  radius_q;
    logic [KEY_W-1:0]  step_q;
  } route_key_t;

  // One row of the directed sequence
  typedef struct {
    req_t            r;
    bit              typed;
    rsp_t            want;
    bit              cfg_wr;
    logic [CFG_W-1:0] cfg_val;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_ready;
  req_t             req = '0;
  logic             rsp_valid;
  logic             rsp_ready = 1'b0;
  rsp_t             rsp;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // Side info that travels with the request in flight
  logic             row_typed = 1'b0;
  rsp_t             row_want = '0;

  // Tag store shadow
  logic [ENTRIES-1:0] ent_valid;
  route_key_t         ent_key[ENTRIES];
  logic [STAMP_W-1:0] ent_stamp[ENTRIES];
  logic [REV_W-1:0]   held_rev;
  logic [STAMP_W-1:0] use_count;
  logic [CFG_W-1:0]   cap_reg;

  rsp_t        owed_rsp[$];
  dir_row_t    dir_rows[$];
  route_key_t  key_pool[POOL_KEYS];
  logic [REV_W-1:0] world_rev;
  int unsigned sent_cnt = 0;
  int unsigned rcvd_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          quiet = 1'b0;

  route_cache_lru_with_flush_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic route_key_t mk_key(logic [15:0] s, logic [15:0] g, logic [15:0] h,
                                        logic [15:0] rd, logic [15:0] st);
    route_key_t k;
    k.start_cell = s;
    k.goal_cell  = g;
    k.hover_q    = h;
    k.radius_q   = rd;
    k.step_q     = st;
    return k;
  endfunction

  function automatic route_key_t fresh_key();
    return mk_key(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                  16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                  16'($urandom_range(16'hFFFF)));
  endfunction

  function automatic req_t mk_req(logic op, route_key_t k, logic [REV_W-1:0] rev);
    req_t r;
    r.opcode         = op;
    r.start_cell     = k.start_cell;
    r.goal_cell      = k.goal_cell;
    r.world_revision = rev;
    r.hover_q        = k.hover_q;
    r.radius_q       = k.radius_q;
    r.step_q         = k.step_q;
    return r;
  endfunction

  function automatic rsp_t mk_rsp(logic h, int s, logic e, logic f, int c);
    rsp_t p;
    p.hit         = h;
    p.slot        = s[SLOT_W-1:0];
    p.evicted     = e;
    p.flushed     = f;
    p.entry_count = c[COUNT_W-1:0];
    return p;
  endfunction

  function automatic int find_entry(route_key_t k);
    for (int i = 0; i < ENTRIES; i++)
      if (ent_valid[i] && ent_key[i] == k) return i;
    return -1;
  endfunction

  // Advance the shadow tag store by one request and return its response
  function automatic rsp_t apply_route_request(req_t r);
    rsp_t        res;
    route_key_t  k;
    int unsigned eff_cap;
    int          idx;
    int          victim;
    res = '0;
    k = mk_key(r.start_cell, r.goal_cell, r.hover_q, r.radius_q, r.step_q);
    eff_cap = (cap_reg == 0) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : cap_reg);

    // revision change drops every entry
    if (r.world_revision != held_rev) begin
      res.flushed = (ent_valid != '0);
      ent_valid = '0;
      held_rev = r.world_revision;
    end

    if (r.opcode == OP_LOOKUP) begin
      idx = find_entry(k);
      if (idx >= 0) begin
        use_count++;
        ent_stamp[idx] = use_count;
        res.hit = 1'b1;
        res.slot = idx[SLOT_W-1:0];
      end
    end else begin
      // full: drop oldest stamp, ties go to smaller start cell, then lower slot
      if ($countones(ent_valid) >= eff_cap) begin
        victim = -1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (ent_valid[i] && (victim < 0 || ent_stamp[i] < ent_stamp[victim] ||
              (ent_stamp[i] == ent_stamp[victim] &&
               ent_key[i].start_cell < ent_key[victim].start_cell)))
            victim = i;
        end
        if (victim >= 0) begin
          ent_valid[victim] = 1'b0;
          res.evicted = 1'b1;
        end
      end
      idx = find_entry(k);
      for (int i = 0; i < ENTRIES && idx < 0; i++)
        if (!ent_valid[i]) idx = i;
      if (idx >= 0) begin
        use_count++;
        ent_valid[idx] = 1'b1;
        ent_key[idx] = k;
        ent_stamp[idx] = use_count;
        res.slot = idx[SLOT_W-1:0];
      end
    end
    res.entry_count = COUNT_W'($countones(ent_valid));
    return res;
  endfunction

  // Monitor: predict on request transactions, check response transactions
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (owed_rsp.size() == 0) begin
          $error("response transaction with no request outstanding");
          err_cnt++;
        end else begin
          want = owed_rsp.pop_front();
          rcvd_cnt++;
          if (rsp.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, rsp.hit);
            err_cnt++;
          end
          if (rsp.slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, rsp.slot);
            err_cnt++;
          end
          if (rsp.evicted !== want.evicted) begin
            $error("evicted: expected %0d, got %0d", want.evicted, rsp.evicted);
            err_cnt++;
          end
          if (rsp.flushed !== want.flushed) begin
            $error("flushed: expected %0d, got %0d", want.flushed, rsp.flushed);
            err_cnt++;
          end
          if (rsp.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, rsp.entry_count);
            err_cnt++;
          end
        end
      end
      if (req_valid && req_ready) begin
        want = apply_route_request(req);
        if (row_typed) want = row_want;
        owed_rsp = {owed_rsp, want};
      end
      if (cfg_we) cap_reg = cfg_wdata;
    end
  end

  // Response side back-pressure
  always @(posedge clk) begin
    rsp_ready <= quiet || ($urandom_range(99) >= 8);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("route_cache_lru_with_flush_unit test failed");
      $finish;
    end
  end

  // Present one request and hold it until accepted
  task automatic push_req(req_t r, bit typed, rsp_t want);
    if (!quiet && $urandom_range(99) < 8) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req       <= r;
    row_typed <= typed;
    row_want  <= want;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    sent_cnt++;
  endtask

  // Drain all outstanding transactions, then write capacity while idle
  task automatic set_capacity(logic [CFG_W-1:0] v);
    req_valid <= 1'b0;
    while (rcvd_cnt != sent_cnt) @(posedge clk);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic add_row(req_t r, bit typed, rsp_t want, bit cfg_wr = 1'b0,
                         logic [CFG_W-1:0] cfg_val = '0);
    dir_row_t row;
    row.r       = r;
    row.typed   = typed;
    row.want    = want;
    row.cfg_wr  = cfg_wr;
    row.cfg_val = cfg_val;
    dir_rows = {dir_rows, row};
  endtask

  // Random request: mostly keys from a small pool so lookups hit
  task automatic next_random_req(output req_t r);
    route_key_t k;
    logic       op;
    if ($urandom_range(99) < 3) begin
      case ($urandom_range(3))
        0: world_rev = {$urandom, $urandom};
        1: world_rev = world_rev + 1;
        2: world_rev = ~world_rev;
        default: world_rev = '0;
      endcase
    end
    if ($urandom_range(99) < 2) key_pool[$urandom_range(POOL_KEYS-1)] = fresh_key();
    k  = ($urandom_range(99) < 12) ? fresh_key() : key_pool[$urandom_range(POOL_KEYS-1)];
    op = ($urandom_range(99) < 45) ? OP_INSERT : OP_LOOKUP;
    r  = mk_req(op, k, world_rev);
  endtask

  initial begin
    route_key_t       ka, kb, kc, kd, ke, kf, kg, kh;
    logic [CFG_W-1:0] cap_plan[PHASES];
    req_t             r;

    ent_valid = '0;
    held_rev  = '0;
    use_count = '0;
    cap_reg   = CAPACITY_RESET;

    ka = mk_key(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    kb = mk_key(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF);
    kc = mk_key(16'h1234, 16'hABCD, 16'h0001, 16'hFFFE, 16'h0100);
    kd = mk_key(16'h5555, 16'hAAAA, 16'h8001, 16'h7FFE, 16'h00FF);
    ke = mk_key(16'h0F0F, 16'hF0F0, 16'hC000, 16'h3FFF, 16'h8000);
    kf = mk_key(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h7FFF);
    kg = mk_key(16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005);
    kh = mk_key(16'hFFFE, 16'h0001, 16'h8000, 16'h7FFF, 16'h0000);

    // Empty cache, hits, extremes, revision flush at reset capacity
    add_row(mk_req(OP_LOOKUP, ka, 64'h0), 1, mk_rsp(0, 0, 0, 0, 0));
    add_row(mk_req(OP_INSERT, ka, 64'h0), 1, mk_rsp(0, 0, 0, 0, 1));
    add_row(mk_req(OP_LOOKUP, ka, 64'h0), 1, mk_rsp(1, 0, 0, 0, 1));
    add_row(mk_req(OP_INSERT, kb, 64'h0), 1, mk_rsp(0, 1, 0, 0, 2));
    add_row(mk_req(OP_LOOKUP, kb, 64'h0), 1, mk_rsp(1, 1, 0, 0, 2));
    add_row(mk_req(OP_LOOKUP, mk_key(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0000),
                   64'h0), 1, mk_rsp(0, 0, 0, 0, 2));
    // insert of a present key rewrites it in place
    add_row(mk_req(OP_INSERT, ka, 64'h0), 1, mk_rsp(0, 0, 0, 0, 2));
    add_row(mk_req(OP_LOOKUP, ka, '1), 1, mk_rsp(0, 0, 0, 1, 0));
    add_row(mk_req(OP_INSERT, ka, '1), 1, mk_rsp(0, 0, 0, 0, 1));
    add_row(mk_req(OP_INSERT, ka, 64'h0), 1, mk_rsp(0, 0, 0, 1, 1));
    add_row(mk_req(OP_LOOKUP, ka, 64'h8000_0000_0000_0000), 1, mk_rsp(0, 0, 0, 1, 0));
    // revision change on an empty cache does not report a flush
    add_row(mk_req(OP_LOOKUP, ka, 64'h1), 1, mk_rsp(0, 0, 0, 0, 0));
    // capacity one: every insert into the full cache evicts, even the same key
    add_row(mk_req(OP_INSERT, kc, 64'h1), 1, mk_rsp(0, 0, 0, 0, 1), 1, 5'd1);
    add_row(mk_req(OP_INSERT, kd, 64'h1), 1, mk_rsp(0, 0, 1, 0, 1));
    add_row(mk_req(OP_INSERT, kd, 64'h1), 1, mk_rsp(0, 0, 1, 0, 1));
    add_row(mk_req(OP_LOOKUP, kd, 64'h1), 1, mk_rsp(1, 0, 0, 0, 1));
    // capacity zero acts as one
    add_row(mk_req(OP_INSERT, kc, 64'h1), 1, mk_rsp(0, 0, 1, 0, 1), 1, 5'd0);
    // capacity above the entry count saturates
    add_row(mk_req(OP_INSERT, ke, 64'h1), 0, '0, 1, 5'd31);
    add_row(mk_req(OP_INSERT, kf, 64'h1), 0, '0);
    // capacity lowered below the live count
    add_row(mk_req(OP_INSERT, kg, 64'h1), 0, '0, 1, 5'd2);
    add_row(mk_req(OP_INSERT, kh, 64'h1), 0, '0);
    add_row(mk_req(OP_INSERT, kg, 64'h1), 0, '0);
    add_row(mk_req(OP_LOOKUP, kh, 64'h1), 0, '0);
    add_row(mk_req(OP_LOOKUP, kc, 64'h1), 0, '0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg_wr) set_capacity(dir_rows[i].cfg_val);
      push_req(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases, each under its own capacity; state carries across phases
    cap_plan = '{5'd16, 5'd31, 5'd1, 5'd4, 5'd0, 5'd17, 5'd2, 5'd9,
                 5'd16, 5'd3, 5'd8, 5'd12};
    cap_plan[7]  = CFG_W'($urandom_range(1, 16));
    cap_plan[11] = CFG_W'($urandom_range(0, 31));
    for (int i = 0; i < POOL_KEYS; i++) key_pool[i] = fresh_key();
    world_rev = 64'h1;

    for (int ph = 0; ph < PHASES; ph++) begin
      set_capacity(cap_plan[ph]);
      quiet = (ph == 8);
      for (int n = 0; n < PHASE_REQS; n++) begin
        next_random_req(r);
        push_req(r, 1'b0, '0);
      end
    end
    quiet = 1'b0;

    // Wind down
    req_valid <= 1'b0;
    while (rcvd_cnt != sent_cnt) @(posedge clk);
    repeat (4) @(posedge clk);
    if (owed_rsp.size() != 0) begin
      $error("%0d responses never arrived", owed_rsp.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("route_cache_lru_with_flush_unit test passed");
    end else begin
      $display("route_cache_lru_with_flush_unit test failed");
    end
    $finish;
  end

endmodule
